FILE: rtl/stp_pkg.sv
`default_nettype none
package stp_pkg;

  localparam int PER_W = 21;
  localparam logic [19:0] PERIOD_SAT = 20'hFFFFF;
  localparam logic [14:0] FREQ_SAT = 15'h7FFF;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_POS  = 2'd1,
    CMD_VEL  = 2'd2,
    CMD_LOAD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_STOP   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_DECEL  = 2'd2,
    PH_CRUISE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MAXSPD = 2'd1,
    ERR_STEP   = 2'd2
  } err_e;

  typedef enum logic {
    CFG_START_SPEED = 1'b0,
    CFG_ACCEL       = 1'b1
  } cfg_e;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_EXEC   = 13'b0000000000010,
    S_PTICK  = 13'b0000000000100,
    S_PPHASE = 13'b0000000001000,
    S_PDIV   = 13'b0000000010000,
    S_P1     = 13'b0000000100000,
    S_P2     = 13'b0000001000000,
    S_P3     = 13'b0000010000000,
    S_P4     = 13'b0000100000000,
    S_V1     = 13'b0001000000000,
    S_V2     = 13'b0010000000000,
    S_FREQ   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/stepper_trapezoid_ramp_generator.sv
`default_nettype none
// Requests use a serial divider with a W-bit dividend, W = max(16, bits of TICKS_PER_SECOND).
// A position start takes four serial divisions, a velocity start three, a position tick two,
// other commands at most one; each division holds its state until the divider is done.
// One request at a time; the next is accepted from the cycle after the result is posted,
// and a result left waiting holds the following one in its last state.
// Reset: asynchronous, active low; position mode, stopped, forward, all counts zero.
module stepper_trapezoid_ramp_generator import stp_pkg::*; #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [14:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] position_value_i,
  input  wire logic [15:0] max_speed_hz_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [20:0]      step_period_o,
  output logic [15:0]      step_rate_o,
  output logic [31:0]      position_o,
  output logic [1:0]       motion_phase_o,
  output logic             running_o,
  output logic             in_position_o,
  output logic             direction_o,
  output logic [1:0]       error_o
);

  localparam int TpsW = $clog2(TICKS_PER_SECOND + 1);
  localparam int DivW = (TpsW > 16) ? TpsW : 16;
  localparam logic [DivW-1:0] Tps = DivW'(TICKS_PER_SECOND);

  function automatic logic [20:0] neg21(input logic [20:0] x);
    neg21 = 21'(0) - x;
  endfunction

  function automatic logic [20:0] abs21(input logic [20:0] x);
    abs21 = x[20] ? 21'(0) - x : x;
  endfunction

  function automatic logic [31:0] dist_dir(input logic [31:0] to, input logic [31:0] from,
                                           input logic fwd);
    logic [31:0] d;
    d = to - from;
    dist_dir = fwd ? d : 32'(0) - d;
  endfunction

  function automatic logic [19:0] psat(input logic [DivW-1:0] q);
    logic [31:0] w;
    w = 32'(q);
    psat = (w > 32'(PERIOD_SAT)) ? PERIOD_SAT : w[19:0];
  endfunction

  state_e      state_q, state_d;
  cmd_e        cmd_q, cmd_d;
  logic [31:0] posv_q, posv_d;
  logic [15:0] maxv_q, maxv_d;
  logic [14:0] fl_q, fl_d, acc_q, acc_d;
  logic [31:0] step_q, step_d, goal_q, goal_d, orig_q, orig_d;
  logic [20:0] per_q, per_d, maxp_q, maxp_d;
  logic [19:0] startp_q, startp_d;
  logic [15:0] prof_q, prof_d, ramp_q, ramp_d, mag_q, mag_d, r_q, r_d, freq_q, freq_d;
  logic [31:0] prog_q, prog_d;
  logic [32:0] lim_q, lim_d;
  logic        vel_q, vel_d, run_q, run_d, inpos_q, inpos_d, fwd_q, fwd_d, dbusy_q, dbusy_d;
  phase_e      phase_q, phase_d;
  err_e        err_q, err_d;
  logic        ov_q, ov_d;
  logic [20:0] o_per_q;
  logic [15:0] o_freq_q;
  logic [31:0] o_pos_q;
  logic [1:0]  o_ph_q, o_err_q;
  logic        o_run_q, o_inpos_q, o_dir_q, o_load;

  logic             div_start, div_done;
  logic [DivW-1:0]  div_dvd, quot;
  logic [PER_W-1:0] div_dsr;

  stp_div #(.DivW(DivW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    div_dvd = Tps;
    div_dsr = '0;
    unique case (state_q)
      S_P1, S_V2: div_dsr = 21'(mag_q);
      S_P2, S_V1: div_dsr = 21'(fl_q);
      S_P3: begin
        div_dvd = DivW'(mag_q - 16'(fl_q));
        div_dsr = 21'(acc_q);
      end
      S_PDIV:     div_dsr = 21'(prof_q);
      S_FREQ:     div_dsr = abs21(per_q);
      default:    div_dsr = '0;
    endcase
  end

  always_comb begin
    logic        t_pos, t_neg, c_pos, c_neg;
    logic [20:0] cur, fhp, flp, sum;
    logic [21:0] dif;
    logic [16:0] sa;
    logic [17:0] sd;
    logic [15:0] s;
    logic [31:0] span, wq;
    state_d  = state_q;
    cmd_d    = cmd_q;
    posv_d   = posv_q;
    maxv_d   = maxv_q;
    fl_d     = fl_q;
    acc_d    = acc_q;
    step_d   = step_q;
    goal_d   = goal_q;
    orig_d   = orig_q;
    per_d    = per_q;
    maxp_d   = maxp_q;
    startp_d = startp_q;
    prof_d   = prof_q;
    ramp_d   = ramp_q;
    mag_d    = mag_q;
    r_d      = r_q;
    freq_d   = freq_q;
    prog_d   = prog_q;
    lim_d    = lim_q;
    vel_d    = vel_q;
    run_d    = run_q;
    inpos_d  = inpos_q;
    fwd_d    = fwd_q;
    phase_d  = phase_q;
    err_d    = err_q;
    dbusy_d  = dbusy_q;
    ov_d     = ov_q;
    o_load   = 1'b0;
    div_start = 1'b0;
    t_pos = !maxp_q[20] && (maxp_q != '0);
    t_neg = maxp_q[20];
    c_pos = !per_q[20] && (per_q != '0);
    c_neg = per_q[20];
    cur   = abs21(per_q);
    fhp   = abs21(maxp_q);
    flp   = 21'(startp_q);
    sum   = '0;
    dif   = '0;
    sa    = '0;
    sd    = '0;
    s     = prof_q;
    span  = dist_dir(goal_q, orig_q, fwd_q);
    wq    = 32'(quot);

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_SPEED: fl_d  = cfg_data_i;
        CFG_ACCEL:       acc_d = cfg_data_i;
        default:         fl_d  = fl_q;
      endcase
    end
    if (out_valid_o && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(command_i);
          posv_d  = position_value_i;
          maxv_d  = max_speed_hz_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FREQ;
        unique case (cmd_q)
          CMD_TICK: begin
            if (run_q && !vel_q) begin
              step_d  = fwd_q ? step_q + 32'd1 : step_q - 32'd1;
              state_d = S_PTICK;
            end else if (run_q) begin
              if ((!t_pos && !t_neg) || flp == '0 || acc_q == '0) begin
                if (!t_pos && !t_neg && (c_pos || c_neg) && cur < flp && flp != '0
                    && acc_q != '0) begin
                  sum = cur + 21'(acc_q);
                  if (sum > flp) sum = flp;
                  per_d = c_neg ? neg21(sum) : sum;
                end else begin
                  per_d   = '0;
                  run_d   = 1'b0;
                  phase_d = PH_STOP;
                end
              end else begin
                if (!c_pos && !c_neg) begin
                  c_pos = t_pos;
                  c_neg = t_neg;
                  cur   = flp;
                end
                if (c_pos != t_pos) begin
                  phase_d = PH_DECEL;
                  if (cur < flp) begin
                    sum = cur + 21'(acc_q);
                    cur = (sum > flp) ? flp : sum;
                  end else begin
                    c_pos = t_pos;
                    c_neg = t_neg;
                    cur   = flp;
                  end
                end else if (cur > fhp) begin
                  phase_d = PH_ACCEL;
                  dif = {1'b0, cur} - 22'(acc_q);
                  cur = (dif[21] || dif[20:0] < fhp) ? fhp : dif[20:0];
                end else if (cur < fhp) begin
                  phase_d = PH_DECEL;
                  sum = cur + 21'(acc_q);
                  cur = (sum > fhp) ? fhp : sum;
                end else begin
                  phase_d = PH_CRUISE;
                end
                per_d  = c_neg ? neg21(cur) : cur;
                step_d = c_pos ? step_q + 32'd1 : step_q - 32'd1;
                fwd_d  = c_pos;
              end
            end
          end
          CMD_POS: begin
            if (maxv_q == '0) begin
              err_d = ERR_MAXSPD;
            end else if (acc_q == '0) begin
              err_d = ERR_STEP;
            end else begin
              err_d   = ERR_NONE;
              inpos_d = 1'b0;
              vel_d   = 1'b0;
              mag_d   = maxv_q[15] ? 16'(0) - maxv_q : maxv_q;
              goal_d  = posv_q;
              orig_d  = step_q;
              state_d = S_P1;
            end
          end
          CMD_VEL: begin
            if (acc_q == '0) begin
              err_d = ERR_STEP;
            end else begin
              err_d   = ERR_NONE;
              inpos_d = 1'b0;
              vel_d   = 1'b1;
              mag_d   = maxv_q[15] ? 16'(0) - maxv_q : maxv_q;
              state_d = S_V1;
            end
          end
          CMD_LOAD: step_d = posv_q;
          default:  step_d = step_q;
        endcase
      end
      S_PTICK: begin
        if (step_q == goal_q) begin
          per_d   = '0;
          run_d   = 1'b0;
          phase_d = PH_STOP;
          inpos_d = 1'b1;
          state_d = S_FREQ;
        end else begin
          prog_d  = dist_dir(step_q, orig_q, fwd_q);
          lim_d   = {1'b0, span} - 33'(ramp_q);
          state_d = S_PPHASE;
        end
      end
      S_PPHASE: begin
        state_d = S_PDIV;
        if (prog_q < 32'(ramp_q)) begin
          phase_d = PH_ACCEL;
          sa = {1'b0, prof_q} + 17'(acc_q);
          s  = (sa > 17'(mag_q)) ? mag_q : sa[15:0];
        end else if ($signed({1'b0, prog_q}) >= $signed(lim_q)) begin
          phase_d = PH_DECEL;
          sd = {2'b0, prof_q} - 18'(acc_q);
          s  = ($signed(sd) < $signed({3'b0, fl_q})) ? 16'(fl_q) : sd[15:0];
        end else begin
          phase_d = PH_CRUISE;
          state_d = S_FREQ;
        end
        prof_d = s;
      end
      S_PDIV: begin
        if (prof_q == '0) begin
          per_d   = '0;
          state_d = S_FREQ;
        end else if (!dbusy_q) begin
          div_start = 1'b1;
          dbusy_d   = 1'b1;
        end else if (div_done) begin
          dbusy_d = 1'b0;
          per_d   = fwd_q ? 21'(psat(quot)) : neg21(21'(psat(quot)));
          state_d = S_FREQ;
        end
      end
      S_P1, S_V2: begin
        if (mag_q == '0) begin
          maxp_d  = '0;
          state_d = (state_q == S_P1) ? S_P2 : S_DONE;
        end else if (!dbusy_q) begin
          div_start = 1'b1;
          dbusy_d   = 1'b1;
        end else if (div_done) begin
          dbusy_d = 1'b0;
          maxp_d  = 21'(psat(quot));
          if (state_q == S_V2 && maxv_q[15]) maxp_d = neg21(21'(psat(quot)));
          state_d = (state_q == S_P1) ? S_P2 : S_DONE;
        end
        if (state_q == S_V2 && state_d == S_DONE) begin
          state_d = S_FREQ;
          if (maxv_q != '0 && !run_q) begin
            run_d   = 1'b1;
            phase_d = PH_ACCEL;
            per_d   = maxv_q[15] ? neg21(21'(startp_q)) : 21'(startp_q);
          end
        end
      end
      S_P2, S_V1: begin
        if (fl_q == '0) begin
          startp_d = '0;
          state_d  = (state_q == S_P2) ? S_P3 : S_V2;
        end else if (!dbusy_q) begin
          div_start = 1'b1;
          dbusy_d   = 1'b1;
        end else if (div_done) begin
          dbusy_d  = 1'b0;
          startp_d = psat(quot);
          state_d  = (state_q == S_P2) ? S_P3 : S_V2;
        end
      end
      S_P3: begin
        if (!dbusy_q) begin
          if (step_q == goal_q) begin
            per_d   = '0;
            run_d   = 1'b0;
            phase_d = PH_STOP;
            inpos_d = 1'b1;
            state_d = S_FREQ;
          end else begin
            fwd_d  = $signed(step_q) < $signed(goal_q);
            prof_d = 16'(fl_q);
            if (mag_q > 16'(fl_q)) begin
              div_start = 1'b1;
              dbusy_d   = 1'b1;
            end else begin
              r_d     = 16'd1;
              state_d = S_P4;
            end
          end
        end else if (div_done) begin
          dbusy_d = 1'b0;
          r_d     = (wq == '0) ? 16'd1 : wq[15:0];
          state_d = S_P4;
        end
      end
      S_P4: begin
        ramp_d  = ({16'd0, r_q, 1'b0} > {1'b0, span}) ? span[16:1] : r_q;
        per_d   = fwd_q ? 21'(startp_q) : neg21(21'(startp_q));
        run_d   = 1'b1;
        phase_d = PH_ACCEL;
        state_d = S_FREQ;
      end
      S_FREQ: begin
        if (per_q == '0) begin
          freq_d  = '0;
          state_d = S_DONE;
        end else if (!dbusy_q) begin
          div_start = 1'b1;
          dbusy_d   = 1'b1;
        end else if (div_done) begin
          dbusy_d = 1'b0;
          freq_d  = (wq > 32'(FREQ_SAT)) ? 16'(FREQ_SAT) : wq[15:0];
          if (per_q[20]) freq_d = 16'(0) - freq_d;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          o_load  = 1'b1;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fl_q     <= '0;
      acc_q    <= '0;
      step_q   <= '0;
      goal_q   <= '0;
      orig_q   <= '0;
      per_q    <= '0;
      maxp_q   <= '0;
      startp_q <= '0;
      prof_q   <= '0;
      ramp_q   <= '0;
      mag_q    <= '0;
      freq_q   <= '0;
      vel_q    <= 1'b0;
      run_q    <= 1'b0;
      inpos_q  <= 1'b0;
      fwd_q    <= 1'b1;
      phase_q  <= PH_STOP;
      err_q    <= ERR_NONE;
      dbusy_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      fl_q     <= fl_d;
      acc_q    <= acc_d;
      step_q   <= step_d;
      goal_q   <= goal_d;
      orig_q   <= orig_d;
      per_q    <= per_d;
      maxp_q   <= maxp_d;
      startp_q <= startp_d;
      prof_q   <= prof_d;
      ramp_q   <= ramp_d;
      mag_q    <= mag_d;
      freq_q   <= freq_d;
      vel_q    <= vel_d;
      run_q    <= run_d;
      inpos_q  <= inpos_d;
      fwd_q    <= fwd_d;
      phase_q  <= phase_d;
      err_q    <= err_d;
      dbusy_q  <= dbusy_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    posv_q <= posv_d;
    maxv_q <= maxv_d;
    r_q    <= r_d;
    prog_q <= prog_d;
    lim_q  <= lim_d;
    if (o_load) begin
      o_per_q   <= per_q;
      o_freq_q  <= freq_q;
      o_pos_q   <= step_q;
      o_ph_q    <= phase_q;
      o_run_q   <= run_q;
      o_inpos_q <= inpos_q;
      o_dir_q   <= fwd_q;
      o_err_q   <= err_q;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ov_q;
  assign step_period_o  = o_per_q;
  assign step_rate_o    = o_freq_q;
  assign position_o     = o_pos_q;
  assign motion_phase_o = o_ph_q;
  assign running_o      = o_run_q;
  assign in_position_o  = o_inpos_q;
  assign direction_o    = o_dir_q;
  assign error_o        = o_err_q;

endmodule
`default_nettype wire

FILE: rtl/stp_div.sv
`default_nettype none
module stp_div import stp_pkg::*; #(
  parameter int DivW = 27
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DivW-1:0]  dividend_i,
  input  wire logic [PER_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DivW-1:0]       quot_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0]  dvd_q, dvd_d;
  logic [PER_W-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [PER_W:0]   remsh;
  logic             qbit;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    remsh  = {rem_q, dvd_q[DivW-1]};
    qbit   = remsh >= {1'b0, divisor_i};
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? PER_W'(remsh - {1'b0, divisor_i}) : remsh[PER_W-1:0];
      dvd_d = {dvd_q[DivW-2:0], qbit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

FILE: tb/ramp_checker.sv
module ramp_checker import stp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] position_value_i,
  input  logic [15:0] max_speed_hz_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [20:0] step_period_i,
  input  logic [15:0] step_rate_i,
  input  logic [31:0] position_i,
  input  logic [1:0]  motion_phase_i,
  input  logic        running_i,
  input  logic        in_position_i,
  input  logic        direction_i,
  input  logic [1:0]  error_i,
  output int          fails_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int TPS = 1000000;

  typedef struct packed {
    logic [20:0] period;
    logic [15:0] freq;
    logic [31:0] pos;
    phase_e      phase;
    logic        run;
    logic        inpos;
    logic        dir;
    err_e        err;
  } step_result_t;

  step_result_t expected_steps[$];

  int unsigned start_hz, accel;
  int          count, goal, origin, cur_period, max_period, start_period;
  int unsigned prof_hz, ramp, max_mag;
  bit          vel_mode, run, inpos, fwd;
  phase_e      phase;
  err_e        err;

  function automatic int hz_period(int unsigned f);
    int unsigned q;
    if (f == 0) return 0;
    q = TPS / f;
    return (q > 1048575) ? 1048575 : q;
  endfunction

  function automatic int period_hz(int p);
    longint m, q;
    if (p == 0) return 0;
    m = (p < 0) ? -longint'(p) : longint'(p);
    q = TPS / m;
    if (q > 32767) q = 32767;
    return (p < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic int unsigned dist_dir(int to, int from);
    int unsigned d;
    d = to - from;
    return fwd ? d : -d;
  endfunction

  task automatic halt_motion();
    cur_period = 0;
    run = 0;
    phase = PH_STOP;
  endtask

  task automatic start_pos_move(int target, int maxv);
    int r;
    int unsigned d;
    if (maxv == 0) begin
      err = ERR_MAXSPD;
      return;
    end
    if (accel == 0) begin
      err = ERR_STEP;
      return;
    end
    err = ERR_NONE;
    inpos = 0;
    vel_mode = 0;
    max_mag = (maxv < 0) ? -maxv : maxv;
    max_period = hz_period(max_mag);
    start_period = hz_period(start_hz);
    goal = target;
    origin = count;
    if (count == target) begin
      halt_motion();
      inpos = 1;
      return;
    end
    fwd = count < target;
    prof_hz = start_hz;
    r = (int'(max_mag) - int'(start_hz)) / int'(accel);
    if (r < 1) r = 1;
    d = dist_dir(goal, origin);
    if (longint'(r) * 2 > longint'(d)) r = d / 2;
    ramp = r;
    cur_period = fwd ? start_period : -start_period;
    run = 1;
    phase = PH_ACCEL;
  endtask

  task automatic start_vel_move(int maxv);
    int p;
    if (accel == 0) begin
      err = ERR_STEP;
      return;
    end
    err = ERR_NONE;
    inpos = 0;
    vel_mode = 1;
    start_period = hz_period(start_hz);
    max_mag = (maxv < 0) ? -maxv : maxv;
    p = hz_period(max_mag);
    max_period = (maxv < 0) ? -p : p;
    if (maxv != 0 && !run) begin
      run = 1;
      phase = PH_ACCEL;
      cur_period = (maxv < 0) ? -start_period : start_period;
    end
  endtask

  task automatic tick_pos();
    int unsigned d, prog;
    int s, p;
    d = dist_dir(goal, origin);
    count = count + (fwd ? 1 : -1);
    if (count == goal) begin
      halt_motion();
      inpos = 1;
      return;
    end
    prog = dist_dir(count, origin);
    if (prog < ramp) begin
      phase = PH_ACCEL;
      s = int'(prof_hz) + int'(accel);
      if (s > int'(max_mag)) s = max_mag;
    end else if (longint'(prog) >= longint'(d) - longint'(ramp)) begin
      phase = PH_DECEL;
      s = int'(prof_hz) - int'(accel);
      if (s < int'(start_hz)) s = start_hz;
    end else begin
      phase = PH_CRUISE;
      return;
    end
    prof_hz = s;
    p = hz_period(s);
    cur_period = fwd ? p : -p;
  endtask

  task automatic tick_vel();
    int tdir, cdir, cur, flp, acc, fhp;
    tdir = (max_period > 0) ? 1 : ((max_period < 0) ? -1 : 0);
    cdir = (cur_period > 0) ? 1 : ((cur_period < 0) ? -1 : 0);
    cur = (cur_period < 0) ? -cur_period : cur_period;
    flp = start_period;
    acc = accel;
    fhp = (max_period < 0) ? -max_period : max_period;
    if (tdir == 0 || flp <= 0 || acc <= 0) begin
      if (tdir == 0 && cdir != 0 && cur < flp && flp > 0 && acc > 0) begin
        cur += acc;
        if (cur > flp) cur = flp;
        cur_period = cdir * cur;
        return;
      end
      halt_motion();
      return;
    end
    if (cdir == 0) begin
      cdir = tdir;
      cur = flp;
    end
    if (cdir != tdir) begin
      phase = PH_DECEL;
      if (cur < flp) begin
        cur += acc;
        if (cur > flp) cur = flp;
      end else begin
        cdir = tdir;
        cur = flp;
      end
    end else if (cur > fhp) begin
      phase = PH_ACCEL;
      cur -= acc;
      if (cur < fhp) cur = fhp;
    end else if (cur < fhp) begin
      phase = PH_DECEL;
      cur += acc;
      if (cur > fhp) cur = fhp;
    end else begin
      phase = PH_CRUISE;
    end
    cur_period = cdir * cur;
    count = count + ((cdir > 0) ? 1 : -1);
    fwd = cdir > 0;
  endtask

  task automatic apply_command(cmd_e cmd, int pv, int maxv);
    step_result_t r;
    case (cmd)
      CMD_TICK: begin
        if (run) begin
          if (vel_mode) tick_vel();
          else tick_pos();
        end
      end
      CMD_POS:  start_pos_move(pv, maxv);
      CMD_VEL:  start_vel_move(maxv);
      default:  count = pv;
    endcase
    r.period = cur_period[20:0];
    r.freq   = 16'(period_hz(cur_period));
    r.pos    = count;
    r.phase  = phase;
    r.run    = run;
    r.inpos  = inpos;
    r.dir    = fwd;
    r.err    = err;
    expected_steps.push_back(r);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d, want %0d", checked_o, field, got, want);
    fails_o++;
  endtask

  assign pending_o = expected_steps.size();

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t w;
    if (!rst_ni) begin
      start_hz = 0; accel = 0; count = 0; goal = 0; origin = 0;
      cur_period = 0; max_period = 0; start_period = 0; prof_hz = 0;
      ramp = 0; max_mag = 0; vel_mode = 0; run = 0; phase = PH_STOP;
      inpos = 0; fwd = 1; err = ERR_NONE;
      fails_o = 0; checked_o = 0;
      expected_steps.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_e'(cfg_index_i) == CFG_START_SPEED) start_hz = cfg_data_i;
        else accel = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("result with no request outstanding", 1, 0);
        end else begin
          w = expected_steps.pop_front();
          if (step_period_i !== w.period)
            report_mismatch("step_period", $signed(step_period_i), $signed(w.period));
          if (step_rate_i !== w.freq)
            report_mismatch("step_rate", $signed(step_rate_i), $signed(w.freq));
          if (position_i !== w.pos)
            report_mismatch("position", $signed(position_i), $signed(w.pos));
          if (motion_phase_i !== w.phase)
            report_mismatch("motion_phase", motion_phase_i, w.phase);
          if (running_i !== w.run) report_mismatch("running", running_i, w.run);
          if (in_position_i !== w.inpos)
            report_mismatch("in_position", in_position_i, w.inpos);
          if (direction_i !== w.dir) report_mismatch("direction", direction_i, w.dir);
          if (error_i !== w.err) report_mismatch("error", error_i, w.err);
        end
        checked_o++;
      end
      if (in_valid_i && in_ready_i)
        apply_command(cmd_e'(command_i), position_value_i, $signed(max_speed_hz_i));
    end
  end

endmodule

FILE: tb/tb.sv
module tb import stp_pkg::*;;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_index_i = 0;
  logic [14:0] cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  command_i = CMD_TICK;
  logic [31:0] position_value_i = 0;
  logic [15:0] max_speed_hz_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [20:0] step_period_o;
  logic [15:0] step_rate_o;
  logic [31:0] position_o;
  logic [1:0]  motion_phase_o;
  logic        running_o, in_position_o, direction_o;
  logic [1:0]  error_o;

  int fails, pending, checked;
  int snd_idle, rcv_idle, sent;
  bit stall_req = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  stepper_trapezoid_ramp_generator DUT (.*);

  ramp_checker u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .position_value_i,
    .max_speed_hz_i, .out_valid_i(out_valid_o), .out_ready_i,
    .step_period_i(step_period_o), .step_rate_i(step_rate_o),
    .position_i(position_o), .motion_phase_i(motion_phase_o),
    .running_i(running_o), .in_position_i(in_position_o),
    .direction_i(direction_o), .error_i(error_o),
    .fails_o(fails), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    #20000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 0;
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic send(cmd_e cmd, logic [31:0] pv, logic [15:0] mv);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    command_i <= cmd;
    position_value_i <= pv;
    max_speed_hz_i <= mv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic ticks(int n);
    repeat (n) send(CMD_TICK, $urandom, 16'($urandom));
  endtask

  task automatic set_regs(logic [14:0] spd, logic [14:0] acc);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= CFG_START_SPEED;
    cfg_data_i <= spd;
    @(posedge clk_i);
    cfg_index_i <= CFG_ACCEL;
    cfg_data_i <= acc;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [15:0] pick_speed();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'h8000;
    if (k == 2) return 16'h7FFF;
    return 16'($urandom_range(1, 5000) * ($urandom_range(1) ? 1 : -1));
  endfunction

  task automatic rand_regs();
    int k;
    k = $urandom_range(5);
    case (k)
      0: set_regs(15'h7FFF, 15'($urandom_range(1, 32767)));
      1: set_regs(15'd0, 15'($urandom_range(1, 200)));
      2: set_regs(15'($urandom_range(1, 400)), 15'h7FFF);
      default: set_regs(15'($urandom_range(1, 800)), 15'($urandom_range(1, 300)));
    endcase
  endtask

  task automatic pos_scenario();
    logic [31:0] v;
    int d;
    v = $urandom_range(3) == 0 ? 32'h7FFFFFF0 + 32'($urandom_range(31)) : $urandom;
    d = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
    if ($urandom_range(1)) d = -d;
    send(CMD_LOAD, v, 16'($urandom));
    send(CMD_POS, v + 32'(d), pick_speed());
    for (int i = 0; i < (d < 0 ? -d : d) + 2; i++) begin
      if ($urandom_range(49) == 0) send(cmd_e'($urandom_range(3)), $urandom, 16'($urandom));
      else send(CMD_TICK, $urandom, 16'($urandom));
    end
  endtask

  task automatic vel_scenario();
    logic [15:0] s;
    s = pick_speed();
    send(CMD_VEL, $urandom, s);
    ticks($urandom_range(10, 120));
    if ($urandom_range(1)) begin
      send(CMD_VEL, $urandom, -s);
      ticks($urandom_range(10, 120));
    end
    send(CMD_VEL, $urandom, 16'd0);
    ticks($urandom_range(5, 200));
  endtask

  initial begin
    snd_idle = 0;
    rcv_idle = 0;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(CMD_TICK, 32'd0, 16'd0);
    send(CMD_POS, 32'd100, 16'd1000);
    set_regs(15'd100, 15'd50);
    send(CMD_POS, 32'd100, 16'd0);
    send(CMD_LOAD, 32'h7FFFFFFF, 16'd0);
    send(CMD_POS, 32'h80000002, 16'h7FFF);
    ticks(4);
    send(CMD_POS, 32'h80000002, 16'd500);
    send(CMD_POS, 32'h7FFFFFF0, 16'h8000);
    ticks(3);
    send(CMD_LOAD, 32'hFFFFFFFF, 16'hFFFF);
    ticks(3);
    send(CMD_VEL, 32'd0, 16'h8000);
    ticks(3);
    send(CMD_VEL, 32'd0, 16'd0);
    ticks(3);
    set_regs(15'd0, 15'h7FFF);
    send(CMD_VEL, 32'd0, 16'h7FFF);
    ticks(2);
    send(CMD_POS, 32'd5, 16'd200);
    ticks(2);

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 32 : ((ph == 1) ? 57 : 0);
      rcv_idle = (ph == 0) ? 57 : ((ph == 1) ? 32 : 0);
      rand_regs();
      stall_req = 1;
      while (sent < 25 + (ph + 1) * 500) begin
        case ($urandom_range(9))
          0: send(cmd_e'($urandom_range(3)), $urandom, 16'($urandom));
          1, 2, 3: vel_scenario();
          default: pos_scenario();
        endcase
        if ($urandom_range(7) == 0) rand_regs();
      end
    end
    set_regs(15'd0, 15'd0);
    send(CMD_POS, 32'd10, 16'd100);
    send(CMD_VEL, 32'd0, 16'd100);

    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked, over position, velocity, load",
             sent, checked);
    $display("and idle commands under several register settings and handshake stalls");
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/stp_pkg.sv
rtl/stp_div.sv
rtl/stepper_trapezoid_ramp_generator.sv
tb/ramp_checker.sv
tb/tb.sv
